// ===== rtl/shacal2_pkg.sv =====
package shacal2_pkg;

	localparam int ROUNDS  = 64;
	localparam int KEY_AW  = 6;
	localparam int KEY_DEPTH = 1 << KEY_AW;

	typedef logic [31:0]       word_t;
	typedef word_t [7:0]       blk_t;   // index 0 = A ... index 7 = H
	typedef logic [KEY_AW-1:0] kaddr_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// beat kinds
	localparam logic KIND_KEY = 1'b0;
	localparam logic KIND_ENC = 1'b1;

	typedef struct packed {
		logic load;   // take a new block and mask
		logic step;   // run one round
	} core_ctl_t;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// one SHA-256 compression round, key word already holds W+K
	function automatic blk_t sha_round(input blk_t s, input word_t kw);
		word_t s1, ch, t1, s0, mj, t2;
		blk_t  r;
		s1 = rotr(s[4], 6) ^ rotr(s[4], 11) ^ rotr(s[4], 25);
		ch = (s[4] & s[5]) ^ (~s[4] & s[6]);
		t1 = s[7] + s1 + ch + kw;
		s0 = rotr(s[0], 2) ^ rotr(s[0], 13) ^ rotr(s[0], 22);
		mj = (s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]);
		t2 = s0 + mj;
		r[7] = s[6];
		r[6] = s[5];
		r[5] = s[4];
		r[4] = s[3] + t1;
		r[3] = s[2];
		r[2] = s[1];
		r[1] = s[0];
		r[0] = t1 + t2;
		return r;
	endfunction

endpackage

// ===== rtl/shacal2_block_encrypt.sv =====
// Encrypt beat: the 64 rounds run on the edges that follow the accepting edge; done is high
// in the cycle after the last round edge, and the result beat is taken in that cycle.
// Busy is high while the rounds run, and a new beat is taken in the cycle where done is high.
// Key-load beat: written to the key store at the accepting edge, no result.
// Reset (arst_n low, asynchronous) clears the sequencer, round counter and done.
// The key store is not cleared; done is a one-cycle strobe and the receiver cannot stall.
module shacal2_block_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [5:0]  key_index,
	input  logic [31:0] key_word,
	input  logic [63:0] block_0,
	input  logic [63:0] block_1,
	input  logic [63:0] block_2,
	input  logic [63:0] block_3,
	input  logic [63:0] mask_0,
	input  logic [63:0] mask_1,
	input  logic [63:0] mask_2,
	input  logic [63:0] mask_3,
	input  logic        use_mask,
	output logic        done,
	output logic [63:0] out_0,
	output logic [63:0] out_1,
	output logic [63:0] out_2,
	output logic [63:0] out_3
);
	import shacal2_pkg::*;

	// Sequencer
	//   ST_IDLE: a start beat is taken. A key beat writes the key store at once.
	//   An encrypt beat loads A..H and the mask, and the key store is read at
	//   address 0 in the same cycle, so round 0's word is ready next cycle.
	//   ST_RUN: round rnd_q uses the key word read last cycle and prefetches
	//   word rnd_q+1. The final round's edge returns to idle and raises done;
	//   the result sits in the working registers until the next encrypt beat.
	state_t    state_q, state_d;
	kaddr_t    rnd_q, rnd_d;
	logic      done_q, done_d;
	logic      accept;
	logic      last_rnd;
	core_ctl_t ctl;
	kaddr_t    raddr;
	word_t     key;

	assign accept   = start && !busy;
	assign last_rnd = (rnd_q == KEY_AW'(ROUNDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rnd_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			rnd_q   <= rnd_d;
			done_q  <= done_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rnd_d    = rnd_q;
		done_d   = 1'b0;
		ctl.load = 1'b0;
		ctl.step = 1'b0;
		raddr    = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && kind == KIND_ENC) begin
					ctl.load = 1'b1;
					rnd_d    = '0;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				ctl.step = 1'b1;
				raddr    = rnd_q + KEY_AW'(1);
				rnd_d    = rnd_q + KEY_AW'(1);
				if (last_rnd) begin
					state_d = ST_IDLE;
					done_d  = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q == ST_RUN);
	assign done = done_q;

	shacal2_key_ram u_key_ram (
		.clk   (clk),
		.we    (accept && kind == KIND_KEY),
		.waddr (key_index),
		.wdata (key_word),
		.raddr (raddr),
		.rdata (key)
	);

	shacal2_round_core u_core (
		.clk      (clk),
		.ctl      (ctl),
		.block_0  (block_0),
		.block_1  (block_1),
		.block_2  (block_2),
		.block_3  (block_3),
		.mask_0   (mask_0),
		.mask_1   (mask_1),
		.mask_2   (mask_2),
		.mask_3   (mask_3),
		.use_mask (use_mask),
		.key      (key),
		.out_0    (out_0),
		.out_1    (out_1),
		.out_2    (out_2),
		.out_3    (out_3)
	);

endmodule

// ===== rtl/shacal2_key_ram.sv =====
module shacal2_key_ram (
	input  logic                clk,
	input  logic                we,
	input  shacal2_pkg::kaddr_t waddr,
	input  shacal2_pkg::word_t  wdata,
	input  shacal2_pkg::kaddr_t raddr,
	output shacal2_pkg::word_t  rdata
);
	import shacal2_pkg::*;

	word_t mem [KEY_DEPTH];
	word_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/shacal2_round_core.sv =====
module shacal2_round_core (
	input  logic                   clk,
	input  shacal2_pkg::core_ctl_t ctl,
	input  logic [63:0]            block_0,
	input  logic [63:0]            block_1,
	input  logic [63:0]            block_2,
	input  logic [63:0]            block_3,
	input  logic [63:0]            mask_0,
	input  logic [63:0]            mask_1,
	input  logic [63:0]            mask_2,
	input  logic [63:0]            mask_3,
	input  logic                   use_mask,
	input  shacal2_pkg::word_t     key,
	output logic [63:0]            out_0,
	output logic [63:0]            out_1,
	output logic [63:0]            out_2,
	output logic [63:0]            out_3
);
	import shacal2_pkg::*;

	blk_t        st_q;
	logic [255:0] mask_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			st_q[0] <= block_0[63:32];
			st_q[1] <= block_0[31:0];
			st_q[2] <= block_1[63:32];
			st_q[3] <= block_1[31:0];
			st_q[4] <= block_2[63:32];
			st_q[5] <= block_2[31:0];
			st_q[6] <= block_3[63:32];
			st_q[7] <= block_3[31:0];
			mask_q  <= use_mask ? {mask_0, mask_1, mask_2, mask_3} : '0;
		end else if (ctl.step) begin
			st_q <= sha_round(st_q, key);
		end
	end

	// mask is zero when unused, so the xor always applies
	assign out_0 = {st_q[0], st_q[1]} ^ mask_q[255:192];
	assign out_1 = {st_q[2], st_q[3]} ^ mask_q[191:128];
	assign out_2 = {st_q[4], st_q[5]} ^ mask_q[127:64];
	assign out_3 = {st_q[6], st_q[7]} ^ mask_q[63:0];

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import shacal2_pkg::*;

	// One input beat as queued for the driver. Unused fields of a kind still
	// carry random data so the block is seen to ignore them.
	typedef struct packed {
		logic             kind;
		logic [5:0]       key_index;
		logic [31:0]      key_word;
		logic [3:0][63:0] blk;       // [0] = A:B ... [3] = G:H
		logic [3:0][63:0] msk;
		logic             use_mask;
		logic [6:0]       idle_pct;  // chance, per cycle, that the driver holds off
	} beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = KIND_KEY;
	logic [5:0]  key_index = '0;
	logic [31:0] key_word = '0;
	logic [63:0] block_0 = '0, block_1 = '0, block_2 = '0, block_3 = '0;
	logic [63:0] mask_0 = '0, mask_1 = '0, mask_2 = '0, mask_3 = '0;
	logic        use_mask = 1'b0;
	logic        busy, done;
	logic [63:0] out_0, out_1, out_2, out_3;

	shacal2_block_encrypt uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.key_index (key_index),
		.key_word  (key_word),
		.block_0   (block_0),
		.block_1   (block_1),
		.block_2   (block_2),
		.block_3   (block_3),
		.mask_0    (mask_0),
		.mask_1    (mask_1),
		.mask_2    (mask_2),
		.mask_3    (mask_3),
		.use_mask  (use_mask),
		.done      (done),
		.out_0     (out_0),
		.out_1     (out_1),
		.out_2     (out_2),
		.out_3     (out_3)
	);

	// Shadow of the key store, updated when a key beat is accepted.
	word_t            round_words [KEY_DEPTH];
	beat_t            pending_beats[$];
	logic [3:0][63:0] cipher_due[$];   // ciphertexts still owed by the block

	int n_key_loads = 0;
	int n_blocks    = 0;
	int n_masked    = 0;
	int n_checked   = 0;
	int n_mismatch  = 0;

	beat_t            taken;
	logic [3:0][63:0] want, got;

	function automatic word_t ror32(input word_t x, input int n);
		logic [63:0] twice;
		twice = {x, x} >> n;
		return twice[31:0];
	endfunction

	// SHACAL-2 forward direction: 64 compression rounds, no feed-forward,
	// then the optional output mask.
	function automatic logic [3:0][63:0] predict_cipher(input logic [3:0][63:0] pt,
			input logic [3:0][63:0] msk, input logic masked);
		word_t a, b, c, d, e, f, g, h;
		word_t sig0, sig1, choose, major, tmp1, tmp2;
		logic [3:0][63:0] ct;
		{a, b} = pt[0];
		{c, d} = pt[1];
		{e, f} = pt[2];
		{g, h} = pt[3];
		for (int r = 0; r < ROUNDS; r++) begin
			sig1   = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
			choose = (e & f) | (~e & g);
			tmp1   = h + sig1 + choose + round_words[r];
			sig0   = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
			major  = (a & b) | (c & (a | b));
			tmp2   = sig0 + major;
			h = g;
			g = f;
			f = e;
			e = d + tmp1;
			d = c;
			c = b;
			b = a;
			a = tmp1 + tmp2;
		end
		ct = {{g, h}, {e, f}, {c, d}, {a, b}};
		if (masked)
			ct = ct ^ msk;
		return ct;
	endfunction

	// Mostly random, with all-zero and all-one words mixed in.
	function automatic logic [63:0] rand_dword();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic add_key_load(input logic [5:0] idx, input word_t w, input int pct);
		beat_t bt;
		bt.kind      = KIND_KEY;
		bt.key_index = idx;
		bt.key_word  = w;
		for (int i = 0; i < 4; i++) begin
			bt.blk[i] = rand_dword();
			bt.msk[i] = rand_dword();
		end
		bt.use_mask = 1'($urandom_range(1));
		bt.idle_pct = 7'(pct);
		pending_beats.push_back(bt);
	endtask

	task automatic add_block(input logic [3:0][63:0] pt, input logic [3:0][63:0] msk,
			input logic masked, input int pct);
		beat_t bt;
		bt.kind      = KIND_ENC;
		bt.key_index = 6'($urandom_range(63));
		bt.key_word  = $urandom;
		bt.blk       = pt;
		bt.msk       = msk;
		bt.use_mask  = masked;
		bt.idle_pct  = 7'(pct);
		pending_beats.push_back(bt);
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver. The beat at the head of the queue is on the ports while start
	// is high; it leaves the queue at the edge that takes it (start && !busy).
	// start stays high across back-to-back beats and is left as it is while a beat waits on busy.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				taken = pending_beats.pop_front();
				if (taken.kind == KIND_KEY) begin
					round_words[taken.key_index] = taken.key_word;
					n_key_loads++;
				end else begin
					// encrypt beat: keys are frozen while busy, so predict now
					cipher_due.push_back(predict_cipher(taken.blk, taken.msk, taken.use_mask));
					n_blocks++;
					if (taken.use_mask)
						n_masked++;
				end
			end
			if (start && busy) begin
				// hold the beat until the engine frees up
			end else if (pending_beats.size() != 0 &&
					$urandom_range(99) >= pending_beats[0].idle_pct) begin
				start     <= 1'b1;
				kind      <= pending_beats[0].kind;
				key_index <= pending_beats[0].key_index;
				key_word  <= pending_beats[0].key_word;
				block_0   <= pending_beats[0].blk[0];
				block_1   <= pending_beats[0].blk[1];
				block_2   <= pending_beats[0].blk[2];
				block_3   <= pending_beats[0].blk[3];
				mask_0    <= pending_beats[0].msk[0];
				mask_1    <= pending_beats[0].msk[1];
				mask_2    <= pending_beats[0].msk[2];
				mask_3    <= pending_beats[0].msk[3];
				use_mask  <= pending_beats[0].use_mask;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor. done marks a one-cycle result beat; the oldest owed ciphertext
	// must match it field by field. Key beats owe nothing, so any extra strobe fails.
	always @(posedge clk) begin
		if (arst_n && done) begin
			got = {out_3, out_2, out_1, out_0};
			if (cipher_due.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("%t: result beat with nothing owed: %h", $realtime, got);
			end else begin
				want = cipher_due.pop_front();
				n_checked++;
				for (int i = 0; i < 4; i++) begin
					if (got[i] !== want[i]) begin
						n_mismatch++;
						if (n_mismatch <= 10)
							$display("%t: out_%0d mismatch, expected %h got %h",
								$realtime, i, want[i], got[i]);
					end
				end
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [3:0][63:0] pt, msk;
		int phase_pct [4];
		phase_pct = '{0, 79, 9, 0};

		// Fill the whole key store first: an unwritten entry must never be read.
		// The ends of the word range sit at the first and last index.
		for (int i = 0; i < KEY_DEPTH; i++)
			add_key_load(6'(i), (i == 0) ? 32'h0 : (i == KEY_DEPTH - 1) ? 32'hFFFF_FFFF :
				$urandom, 0);

		// Directed: block and mask extremes, mask on and off, key overwrites
		// between blocks, back-to-back encryptions.
		add_block('0, '0, 1'b0, 0);
		add_block('1, '0, 1'b0, 0);
		add_block('0, '1, 1'b1, 0);
		add_block('1, '1, 1'b1, 0);
		add_block({4{64'hAAAA_AAAA_AAAA_AAAA}}, {4{64'h5555_5555_5555_5555}}, 1'b1, 0);
		add_block({4{64'h5555_5555_5555_5555}}, '1, 1'b0, 0);  // mask present but off
		add_key_load(6'd0, 32'hFFFF_FFFF, 0);
		add_key_load(6'd63, 32'h0, 0);
		add_block('0, '0, 1'b0, 0);
		add_key_load(6'd31, 32'h8000_0001, 0);
		for (int i = 0; i < 4; i++) begin
			pt[i]  = {$urandom, $urandom};
			msk[i] = {$urandom, $urandom};
		end
		add_block(pt, msk, 1'b1, 0);
		add_block(pt, msk, 1'b0, 0);
		add_key_load(6'd0, 32'h0, 0);
		add_block(pt, msk, 1'b1, 0);

		// Random: four phases of sender idling, roughly half key beats.
		for (int p = 0; p < 4; p++) begin
			for (int n = 0; n < 400; n++) begin
				if ($urandom_range(99) < 45) begin
					add_key_load(6'($urandom_range(63)), $urandom_range(7) == 0 ?
						($urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF) : $urandom, phase_pct[p]);
				end else begin
					for (int i = 0; i < 4; i++) begin
						pt[i]  = rand_dword();
						msk[i] = rand_dword();
					end
					add_block(pt, msk, 1'($urandom_range(1)), phase_pct[p]);
				end
			end
		end

		// Drain: every beat taken, every ciphertext back, then a round trip more.
		while (pending_beats.size() != 0 || start)
			@(posedge clk);
		while (cipher_due.size() != 0)
			@(posedge clk);
		repeat (70) @(posedge clk);

		$display("covered %0d key loads and %0d block encryptions (%0d with mask)",
			n_key_loads, n_blocks, n_masked);
		$display("%0d ciphertexts checked, %0d mismatches", n_checked, n_mismatch);
		if (n_mismatch == 0 && cipher_due.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

	// Watchdog, well past the slowest legal run.
	initial begin
		#4_000_000;
		$display("tb_top failed");
		$finish;
	end

endmodule
